FILE: hw/rtl/bsb_pkg.sv
package bsb_pkg;

    localparam int unsigned SQ_W   = 6;
    localparam int unsigned MASK_W = 64;
    localparam int unsigned COORD_W = 3;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_status;

endpackage

FILE: hw/rtl/bsb_ctrl.sv
module bsb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_stall,
    input  bsb_pkg::t_status i_status,
    output bsb_pkg::t_cmd    o_cmd,
    output logic            o_in_stall,
    output logic            o_out_valid
);

    bsb_pkg::t_state r_state;
    bsb_pkg::t_state n_state;
    logic            in_ready;
    logic            out_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        out_take  = 1'b0;
        in_ready  = 1'b0;
        o_cmd     = '0;
        case (r_state)
            bsb_pkg::ST_IDLE: begin
                in_ready = 1'b1;
            end
            bsb_pkg::ST_EMIT: begin
                out_take = !i_out_stall;
                // final transaction leaving frees the datapath in the same cycle
                in_ready = out_take && i_status.last;
                o_cmd.advance = out_take && !i_status.last;
                if (out_take && i_status.last) begin
                    n_state = bsb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bsb_pkg::ST_IDLE;
            end
        endcase
        o_cmd.load = i_in_valid && in_ready;
        if (o_cmd.load) begin
            n_state = bsb_pkg::ST_EMIT;
        end
    end

    assign o_in_stall  = !in_ready;
    assign o_out_valid = (r_state == bsb_pkg::ST_EMIT);

endmodule

FILE: hw/rtl/bsb_dp.sv
module bsb_dp (
    input  logic                         i_clk,
    input  bsb_pkg::t_cmd                i_cmd,
    input  logic [bsb_pkg::SQ_W-1:0]     i_from_square,
    input  logic [bsb_pkg::SQ_W-1:0]     i_to_square,
    output bsb_pkg::t_status             o_status,
    output logic [bsb_pkg::SQ_W-1:0]     o_between_square,
    output logic [bsb_pkg::MASK_W-1:0]   o_between_mask,
    output logic                         o_is_last,
    output logic                         o_none_between
);

    logic [bsb_pkg::MASK_W-1:0]  r_full;
    logic [bsb_pkg::MASK_W-1:0]  r_rest;
    logic [bsb_pkg::MASK_W-1:0]  n_mask;
    logic [bsb_pkg::MASK_W-1:0]  rest_dec;
    logic [bsb_pkg::MASK_W-1:0]  low_bit;
    logic [bsb_pkg::SQ_W-1:0]    low_idx;

    logic [bsb_pkg::COORD_W-1:0] r1, f1, r2, f2;
    logic [bsb_pkg::COORD_W-1:0] lo_r, hi_r, lo_f, hi_f;
    logic                        same_rank, same_file, on_diag, on_anti;

    assign r1 = i_from_square[5:3];
    assign f1 = i_from_square[2:0];
    assign r2 = i_to_square[5:3];
    assign f2 = i_to_square[2:0];

    always_comb begin
        lo_r = (r1 < r2) ? r1 : r2;
        hi_r = (r1 < r2) ? r2 : r1;
        lo_f = (f1 < f2) ? f1 : f2;
        hi_f = (f1 < f2) ? f2 : f1;
        same_rank = (r1 == r2);
        same_file = (f1 == f2);
        // r - f constant on a diagonal, r + f constant on an anti-diagonal
        on_diag = ({1'b0, r1} + {1'b0, f2}) == ({1'b0, r2} + {1'b0, f1});
        on_anti = ({1'b0, r1} + {1'b0, f1}) == ({1'b0, r2} + {1'b0, f2});
    end

    // each square tested on its own against the segment
    always_comb begin
        logic [bsb_pkg::COORD_W-1:0] r, f;
        logic [bsb_pkg::SQ_W-1:0]    s;
        logic                        in_r, in_f;
        for (int i = 0; i < bsb_pkg::MASK_W; i++) begin
            s    = bsb_pkg::SQ_W'(i);
            r    = s[5:3];
            f    = s[2:0];
            in_r = (r > lo_r) && (r < hi_r);
            in_f = (f > lo_f) && (f < hi_f);
            n_mask[i] = (same_rank && (r == r1) && in_f)
                     || (same_file && (f == f1) && in_r)
                     || (on_diag && (({1'b0, r} + {1'b0, f1}) == ({1'b0, r1} + {1'b0, f}))
                         && in_r)
                     || (on_anti && (({1'b0, r} + {1'b0, f}) == ({1'b0, r1} + {1'b0, f1}))
                         && in_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_full <= n_mask;
            r_rest <= n_mask;
        end else if (i_cmd.advance) begin
            r_rest <= r_rest & rest_dec;
        end
    end

    assign rest_dec = r_rest - bsb_pkg::MASK_W'(1);
    assign low_bit  = r_rest & (~r_rest + bsb_pkg::MASK_W'(1));

    always_comb begin
        low_idx = '0;
        for (int i = 0; i < bsb_pkg::MASK_W; i++) begin
            if (low_bit[i]) begin
                low_idx = low_idx | bsb_pkg::SQ_W'(i);
            end
        end
    end

    assign o_status.last    = ((r_rest & rest_dec) == '0);
    assign o_between_square = low_idx;
    assign o_between_mask   = r_full;
    assign o_is_last        = o_status.last;
    assign o_none_between   = (r_full == '0);

endmodule

FILE: hw/rtl/bitboard_squares_between_top.sv
// Squares strictly between two squares of an 8x8 board (index = rank*8 + file).
// Input channel: i_in_valid / o_in_stall carry i_from_square and i_to_square.
// Output channel: o_out_valid / i_out_stall carry one in-between square per
// transaction in ascending order, the full 64-bit set, a last flag, and a
// none flag (single transaction, square 0, mask 0) when the set is empty.
// The first result is valid in the cycle after the input transaction.
// One result per cycle while the output is not stalled; an input produces
// at most 6 results. The set register is walked by a lowest-bit priority
// encoder, and a new input is taken in the same cycle the last result of
// the previous one is taken.
// A stall on the output holds all result fields and the input stays stalled.
// Reset (synchronous, active low) returns the controller to idle; any
// partially emitted result list is dropped.
module bitboard_squares_between_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [5:0]  i_from_square,
    input  logic [5:0]  i_to_square,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_between_square,
    output logic [63:0] o_between_mask,
    output logic        o_is_last,
    output logic        o_none_between
);

    bsb_pkg::t_cmd    cmd;
    bsb_pkg::t_status status;

    bsb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    bsb_dp u_dp (
        .i_clk            (i_clk),
        .i_cmd            (cmd),
        .i_from_square    (i_from_square),
        .i_to_square      (i_to_square),
        .o_status         (status),
        .o_between_square (o_between_square),
        .o_between_mask   (o_between_mask),
        .o_is_last        (o_is_last),
        .o_none_between   (o_none_between)
    );

    a_in_gives_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted input produced no result");

    a_none_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_none_between |->
            o_is_last && (o_between_mask == 64'd0) && (o_between_square == 6'd0))
        else $error("empty-set result malformed");

    a_square_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_none_between |-> o_between_mask[o_between_square])
        else $error("emitted square not in set");

    a_busy_stalls_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_last |-> o_in_stall)
        else $error("input taken while results remain");

endmodule
